[src/htfd_pkg.sv]
// Shared types, codes and the CRC-8 step function for the humidity/temperature frame decoder.
package htfd_pkg;

    // CRC-8, polynomial x^8+x^5+x^4+1, all-ones start value, MSB first
    localparam logic [7:0] CRC_INIT   = 8'hFF;
    localparam logic [7:0] CRC_POLY   = 8'h31;

    // Scale factors and offset of the conversions (full scale is 65535)
    localparam logic [13:0] HUM_SCALE  = 14'd10000;
    localparam logic [14:0] TEMP_SCALE = 15'd17500;
    localparam logic [15:0] FULL_SCALE = 16'hFFFF;
    localparam logic [15:0] TEMP_OFFS  = 16'd4500;

    // Product width: 16-bit word times a scale below 2^15
    localparam int PROD_W = 31;

    // Position of the next byte in the six-byte frame
    typedef enum logic [2:0] {
        POS_HUM_HI,
        POS_HUM_LO,
        POS_HUM_CRC,
        POS_TMP_HI,
        POS_TMP_LO,
        POS_TMP_CRC
    } byte_pos_t;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_HUM_BAD  = 2'd1,
        STATUS_TEMP_BAD = 2'd2
    } status_t;

    // Checked frame handed from the framer to the scaling pipeline
    typedef struct packed {
        logic [15:0] hum_word;
        logic [15:0] temp_word;
        status_t     status;
    } frame_word_t;

    // One byte through the CRC register, eight shift steps
    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[src/htfd_framer.sv]
// Byte framer: tracks the frame position, runs the CRC and collects both words.
module htfd_framer
    import htfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_frame_start,
    output logic        frm_valid,
    input  logic        frm_ready,
    output frame_word_t frm_data
);

    byte_pos_t   pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [7:0]  high_reg, high_next;
    logic [15:0] hum_reg, hum_next;
    logic        hum_bad_reg, hum_bad_next;
    logic        valid_reg, valid_next;
    frame_word_t data_reg, data_next;

    byte_pos_t   pos_cur;
    logic        accept;

    assign s_ready   = !valid_reg || frm_ready;
    assign accept    = s_valid && s_ready;
    assign frm_valid = valid_reg;
    assign frm_data  = data_reg;

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= POS_HUM_HI;
            crc_reg     <= CRC_INIT;
            high_reg    <= '0;
            hum_reg     <= '0;
            hum_bad_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            crc_reg     <= crc_next;
            high_reg    <= high_next;
            hum_reg     <= hum_next;
            hum_bad_reg <= hum_bad_next;
            valid_reg   <= valid_next;
        end
    end

    // Result payload, no reset
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    // Next state: start flag forces byte 0
    always_comb begin
        pos_cur      = s_frame_start ? POS_HUM_HI : pos_reg;
        pos_next     = pos_reg;
        crc_next     = crc_reg;
        high_next    = high_reg;
        hum_next     = hum_reg;
        hum_bad_next = hum_bad_reg;
        valid_next   = valid_reg && !frm_ready;
        data_next    = data_reg;
        if (accept) begin
            unique case (pos_cur) inside
                POS_HUM_HI, POS_TMP_HI: begin
                    high_next = s_data_byte;
                    crc_next  = crc_feed(CRC_INIT, s_data_byte);
                    pos_next  = (pos_cur == POS_HUM_HI) ? POS_HUM_LO : POS_TMP_LO;
                end
                POS_HUM_LO: begin
                    hum_next = {high_reg, s_data_byte};
                    crc_next = crc_feed(crc_reg, s_data_byte);
                    pos_next = POS_HUM_CRC;
                end
                POS_HUM_CRC: begin
                    hum_bad_next = (s_data_byte != crc_reg);
                    crc_next     = CRC_INIT;
                    pos_next     = POS_TMP_HI;
                end
                POS_TMP_LO: begin
                    // temperature word goes straight into the result
                    data_next.temp_word = {high_reg, s_data_byte};
                    crc_next            = crc_feed(crc_reg, s_data_byte);
                    pos_next            = POS_TMP_CRC;
                end
                POS_TMP_CRC: begin
                    data_next.hum_word = hum_reg;
                    if (hum_bad_reg) begin
                        data_next.status = STATUS_HUM_BAD;
                    end else if (s_data_byte != crc_reg) begin
                        data_next.status = STATUS_TEMP_BAD;
                    end else begin
                        data_next.status = STATUS_OK;
                    end
                    crc_next   = CRC_INIT;
                    pos_next   = POS_HUM_HI;
                    valid_next = 1'b1;
                end
                default: begin
                    // unused position codes behave as byte 0
                    high_next = s_data_byte;
                    crc_next  = crc_feed(CRC_INIT, s_data_byte);
                    pos_next  = POS_HUM_LO;
                end
            endcase
        end
    end

endmodule

[src/htfd_scale.sv]
// Two-stage conversion: constant multiply, then exact divide by 65535 and offset.
module htfd_scale
    import htfd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               frm_valid,
    output logic               frm_ready,
    input  frame_word_t        frm_data,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [13:0]        m_humidity_centi,
    output logic signed [14:0] m_temperature_centi,
    output logic [1:0]         m_status
);

    logic              prod_valid_reg;
    logic [PROD_W-1:0] hum_prod_reg;
    logic [PROD_W-1:0] temp_prod_reg;
    status_t           prod_status_reg;

    logic              out_valid_reg;
    logic [13:0]       hum_out_reg;
    logic [14:0]       temp_out_reg;
    status_t           status_out_reg;

    logic              out_adv;
    logic              prod_adv;
    logic [14:0]       hum_q;
    logic [14:0]       temp_q;
    logic [15:0]       temp_s;

    // floor(x / 65535) for x < 2^31: x = q0*65536 + lo, remainder guess lo + q0
    function automatic logic [14:0] div_full_scale(input logic [PROD_W-1:0] x);
        logic [14:0] q0;
        logic [16:0] rem;
        q0  = x[PROD_W-1:16];
        rem = {1'b0, x[15:0]} + {2'b00, q0};
        return q0 + 15'(rem >= {1'b0, FULL_SCALE});
    endfunction

    assign out_adv   = !out_valid_reg || m_ready;
    assign prod_adv  = !prod_valid_reg || out_adv;
    assign frm_ready = prod_adv;

    // Stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (prod_adv) begin
                prod_valid_reg <= frm_valid;
            end
            if (out_adv) begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    // Stage 1: scale products, both operands widened to the product width
    always_ff @(posedge aclk) begin
        if (prod_adv && frm_valid) begin
            hum_prod_reg    <= PROD_W'(frm_data.hum_word) * PROD_W'(HUM_SCALE);
            temp_prod_reg   <= PROD_W'(frm_data.temp_word) * PROD_W'(TEMP_SCALE);
            prod_status_reg <= frm_data.status;
        end
    end

    // Stage 2: divide by full scale, apply temperature offset
    assign hum_q  = div_full_scale(hum_prod_reg);
    assign temp_q = div_full_scale(temp_prod_reg);
    assign temp_s = {1'b0, temp_q} - TEMP_OFFS;

    always_ff @(posedge aclk) begin
        if (out_adv && prod_valid_reg) begin
            hum_out_reg    <= hum_q[13:0];
            temp_out_reg   <= temp_s[14:0];
            status_out_reg <= prod_status_reg;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_humidity_centi    = hum_out_reg;
    assign m_temperature_centi = temp_out_reg;
    assign m_status            = status_out_reg;

endmodule

[src/humidity_temp_frame_decoder.sv]
// Top level of the humidity/temperature sensor frame decoder.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | data_byte[7:0], frame_start
//  m_      | out       | m_valid / m_ready  | humidity_centi[13:0], temperature_centi[14:0] s,
//          |           |                    | status[1:0]
//
// One byte is taken per cycle while s_ready is high; the framer and two scaling stages are
// each one register deep. The sixth byte loads the framer register at its accepting edge;
// the multiply and divide registers follow, and m_valid rises once the divide register loads.
// Synchronous active-low reset clears the frame position, CRC and all valid flags.
// A stalled output holds its transaction; stages upstream keep filling until each is full.
module humidity_temp_frame_decoder
    import htfd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_data_byte,
    input  logic               s_frame_start,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [13:0]        m_humidity_centi,
    output logic signed [14:0] m_temperature_centi,
    output logic [1:0]         m_status
);

    logic        frm_valid;
    logic        frm_ready;
    frame_word_t frm_data;

    // Byte framing and CRC check
    htfd_framer u_framer (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_frame_start (s_frame_start),
        .frm_valid     (frm_valid),
        .frm_ready     (frm_ready),
        .frm_data      (frm_data)
    );

    // Unit conversion
    htfd_scale u_scale (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .frm_valid           (frm_valid),
        .frm_ready           (frm_ready),
        .frm_data            (frm_data),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_humidity_centi    (m_humidity_centi),
        .m_temperature_centi (m_temperature_centi),
        .m_status            (m_status)
    );

endmodule
